>>> rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside of reset
`define URS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// check a property on every clock edge, reset included
`define URS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/core/urs_pkg.sv
// shared types and codes for the undo/redo stack pair
package urs_pkg;

    // command modes
    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_UNDO = 2'd1,
        MODE_REDO = 2'd2
    } mode_e;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_MAIN_FULL  = 2'd1,
        STAT_MAIN_EMPTY = 2'd2,
        STAT_HIST_EMPTY = 2'd3
    } status_e;

    // source of the song reported in a result
    typedef enum logic [1:0] {
        MOVED_NONE = 2'd0,
        MOVED_MAIN = 2'd1,
        MOVED_HIST = 2'd2
    } moved_sel_e;

    // command beat
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] song_id;
    } urs_cmd_t;

    // result beat
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] moved_song;
        logic       dropped_oldest;
        logic [3:0] main_count;
        logic [2:0] history_count;
    } urs_rsp_t;

    // per-command control decoded at accept time
    typedef struct packed {
        logic       main_we;
        logic       main_src_hist;
        logic       hist_we;
        moved_sel_e moved_sel;
        status_e    status;
        logic       dropped;
    } urs_flags_t;

endpackage

>>> rtl/core/urs_ram.sv
// generic single-port-write, registered-read ram
module urs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/urs_ptr.sv
// stack depths, history ring pointer and command decode
module urs_ptr #(
    parameter int MAIN_DEPTH    = 10,
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           accept,
    input  logic [1:0]                                     mode,
    output urs_pkg::urs_flags_t                            flags,
    output logic [(MAIN_DEPTH > 1 ? $clog2(MAIN_DEPTH) : 1)-1:0]       main_raddr,
    output logic [(MAIN_DEPTH > 1 ? $clog2(MAIN_DEPTH) : 1)-1:0]       main_waddr,
    output logic [(HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1)-1:0] hist_raddr,
    output logic [(HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1)-1:0] hist_waddr,
    output logic [$clog2(MAIN_DEPTH+1)-1:0]                main_count,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]             hist_count
);
    import urs_pkg::*;

    localparam int MAW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int MCW = $clog2(MAIN_DEPTH + 1);
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);

    logic [MCW-1:0] main_cnt_reg, main_cnt_next;
    logic [HCW-1:0] hist_cnt_reg, hist_cnt_next;
    logic [HAW-1:0] hist_old_reg, hist_old_next;

    logic           main_full, main_empty, hist_full, hist_empty;
    logic [HAW-1:0] hist_old_inc;
    logic [HAW-1:0] ring_rd, ring_wr;

    // ring slot at offset from the oldest entry, both below the depth
    function automatic logic [HAW-1:0] ring_slot(input logic [HAW-1:0] base,
                                                 input logic [HCW-1:0] off);
        logic [HCW:0] sum;
        sum = (HCW+1)'(base) + (HCW+1)'(off);
        if (sum >= (HCW+1)'(HISTORY_DEPTH))
        begin
            sum = sum - (HCW+1)'(HISTORY_DEPTH);
        end
        return HAW'(sum);
    endfunction

    // occupancy flags and ring addresses
    always_comb
    begin
        main_full    = (main_cnt_reg == MCW'(MAIN_DEPTH));
        main_empty   = (main_cnt_reg == '0);
        hist_full    = (hist_cnt_reg == HCW'(HISTORY_DEPTH));
        hist_empty   = (hist_cnt_reg == '0);
        hist_old_inc = (hist_old_reg == HAW'(HISTORY_DEPTH - 1)) ? '0
                                                                 : hist_old_reg + 1'b1;
        ring_rd      = ring_slot(hist_old_reg, hist_cnt_reg - 1'b1);
        ring_wr      = hist_full ? ring_slot(hist_old_inc, HCW'(HISTORY_DEPTH - 1))
                                 : ring_slot(hist_old_reg, hist_cnt_reg);
    end

    // command decode and next depths
    always_comb
    begin
        main_cnt_next = main_cnt_reg;
        hist_cnt_next = hist_cnt_reg;
        hist_old_next = hist_old_reg;
        flags         = '0;
        flags.status    = STAT_OK;
        flags.moved_sel = MOVED_NONE;
        main_raddr    = MAW'(main_cnt_reg - 1'b1);
        main_waddr    = MAW'(main_cnt_reg);
        hist_raddr    = ring_rd;
        hist_waddr    = ring_wr;
        case (mode)
            MODE_PUSH:
            begin
                if (main_full)
                begin
                    flags.status = STAT_MAIN_FULL;
                end
                else
                begin
                    flags.main_we = 1'b1;
                    main_cnt_next = main_cnt_reg + 1'b1;
                end
            end
            MODE_UNDO:
            begin
                if (main_empty)
                begin
                    flags.status = STAT_MAIN_EMPTY;
                end
                else
                begin
                    main_cnt_next   = main_cnt_reg - 1'b1;
                    flags.moved_sel = MOVED_MAIN;
                    flags.hist_we   = 1'b1;
                    if (hist_full)
                    begin
                        // oldest entry gives way, its slot takes the new one
                        hist_old_next = hist_old_inc;
                        flags.dropped = 1'b1;
                    end
                    else
                    begin
                        hist_cnt_next = hist_cnt_reg + 1'b1;
                    end
                end
            end
            MODE_REDO:
            begin
                if (hist_empty)
                begin
                    flags.status = STAT_HIST_EMPTY;
                end
                else
                begin
                    hist_cnt_next   = hist_cnt_reg - 1'b1;
                    flags.moved_sel = MOVED_HIST;
                    if (main_full)
                    begin
                        // popped song is lost
                        flags.status = STAT_MAIN_FULL;
                    end
                    else
                    begin
                        flags.main_we       = 1'b1;
                        flags.main_src_hist = 1'b1;
                        main_cnt_next       = main_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                flags.status = STAT_OK;
            end
        endcase
    end

    assign main_count = main_cnt_next;
    assign hist_count = hist_cnt_next;

    // depth and ring pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_cnt_reg <= '0;
            hist_cnt_reg <= '0;
            hist_old_reg <= '0;
        end
        else if (accept)
        begin
            main_cnt_reg <= main_cnt_next;
            hist_cnt_reg <= hist_cnt_next;
            hist_old_reg <= hist_old_next;
        end
    end

endmodule

>>> rtl/core/urs_exec.sv
// execute stage: song stores, write-back and read bypass
module urs_exec #(
    parameter int MAIN_DEPTH    = 10,
    parameter int HISTORY_DEPTH = 5,
    parameter int SONG_BITS     = 8
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           advance,
    input  logic                                           accept,
    input  logic [7:0]                                     song_id,
    input  urs_pkg::urs_flags_t                            flags,
    input  logic [(MAIN_DEPTH > 1 ? $clog2(MAIN_DEPTH) : 1)-1:0]       main_raddr,
    input  logic [(MAIN_DEPTH > 1 ? $clog2(MAIN_DEPTH) : 1)-1:0]       main_waddr,
    input  logic [(HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1)-1:0] hist_raddr,
    input  logic [(HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1)-1:0] hist_waddr,
    input  logic [$clog2(MAIN_DEPTH+1)-1:0]                main_count,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0]             hist_count,
    output logic                                           busy,
    output urs_pkg::urs_rsp_t                              result
);
    import urs_pkg::*;

    localparam int MAW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int MCW = $clog2(MAIN_DEPTH + 1);
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);

    logic                 s1_valid_reg;
    urs_flags_t           s1_flags_reg;
    logic [SONG_BITS-1:0] s1_song_reg;
    logic [MAW-1:0]       s1_mwaddr_reg;
    logic [HAW-1:0]       s1_hwaddr_reg;
    logic [MCW-1:0]       s1_mcnt_reg;
    logic [HCW-1:0]       s1_hcnt_reg;
    logic                 s1_mbyp_reg, s1_mbyp_next;
    logic                 s1_hbyp_reg, s1_hbyp_next;
    logic [SONG_BITS-1:0] s1_mbyp_data_reg;
    logic [SONG_BITS-1:0] s1_hbyp_data_reg;

    logic [SONG_BITS-1:0] main_q, hist_q;
    logic [SONG_BITS-1:0] main_rd, hist_rd;
    logic [SONG_BITS-1:0] main_wdata, hist_wdata;
    logic                 main_we, hist_we;
    logic [SONG_BITS-1:0] moved;

    // read data, taking the write that landed alongside the read
    always_comb
    begin
        main_rd    = s1_mbyp_reg ? s1_mbyp_data_reg : main_q;
        hist_rd    = s1_hbyp_reg ? s1_hbyp_data_reg : hist_q;
        main_wdata = s1_flags_reg.main_src_hist ? hist_rd : s1_song_reg;
        hist_wdata = main_rd;
        main_we    = advance && s1_valid_reg && s1_flags_reg.main_we;
        hist_we    = advance && s1_valid_reg && s1_flags_reg.hist_we;
        s1_mbyp_next = main_we && (s1_mwaddr_reg == main_raddr);
        s1_hbyp_next = hist_we && (s1_hwaddr_reg == hist_raddr);
    end

    urs_ram #(
        .WIDTH (SONG_BITS),
        .DEPTH (MAIN_DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (main_we),
        .waddr (s1_mwaddr_reg),
        .wdata (main_wdata),
        .re    (accept),
        .raddr (main_raddr),
        .rdata (main_q)
    );

    urs_ram #(
        .WIDTH (SONG_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (s1_hwaddr_reg),
        .wdata (hist_wdata),
        .re    (accept),
        .raddr (hist_raddr),
        .rdata (hist_q)
    );

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_flags_reg     <= flags;
            s1_song_reg      <= SONG_BITS'(song_id);
            s1_mwaddr_reg    <= main_waddr;
            s1_hwaddr_reg    <= hist_waddr;
            s1_mcnt_reg      <= main_count;
            s1_hcnt_reg      <= hist_count;
            s1_mbyp_reg      <= s1_mbyp_next;
            s1_hbyp_reg      <= s1_hbyp_next;
            s1_mbyp_data_reg <= main_wdata;
            s1_hbyp_data_reg <= hist_wdata;
        end
    end

    // song reported in the result
    always_comb
    begin
        case (s1_flags_reg.moved_sel)
            MOVED_MAIN: moved = main_rd;
            MOVED_HIST: moved = hist_rd;
            default:    moved = '0;
        endcase
    end

    // result beat
    always_comb
    begin
        result.status         = s1_flags_reg.status;
        result.moved_song     = 8'(moved);
        result.dropped_oldest = s1_flags_reg.dropped;
        result.main_count     = 4'(s1_mcnt_reg);
        result.history_count  = 3'(s1_hcnt_reg);
    end

    assign busy = s1_valid_reg;

endmodule

>>> rtl/core/undo_redo_stack_pair.sv
// top level of the bounded undo/redo stack pair
//
// Command channel cmd_valid/cmd_ready/cmd carries one beat per operation:
// push a song onto the main stack, undo (main stack to history ring) or
// redo (history ring back to the main stack). Every command beat yields
// exactly one beat on rsp_valid/rsp_ready/rsp with the status, the song
// that moved, the discard flag and both depths after the operation.
// A command taken is held in the execute stage register and then in the
// result register, which drives rsp. Throughput: one command per cycle
// while rsp_ready does not stall; the song stores are rams with a
// registered read, read at accept and written back from the execute stage,
// with a one-entry bypass covering a read of the slot being written.
// Reset clears both depths and the ring pointer and drops any beat in
// flight; store contents are not cleared and need no clearing pass.
// When the receiver holds rsp_ready low, the result register keeps its
// beat, the execute stage holds, and cmd_ready goes low until the result
// register frees up.
module undo_redo_stack_pair #(
    parameter int MAIN_DEPTH    = 10,
    parameter int HISTORY_DEPTH = 5,
    parameter int SONG_BITS     = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  urs_pkg::urs_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output urs_pkg::urs_rsp_t rsp
);
    import urs_pkg::*;

    localparam int MAW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int MCW = $clog2(MAIN_DEPTH + 1);
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);

    logic           advance, accept, busy;
    urs_flags_t     flags;
    logic [MAW-1:0] main_raddr, main_waddr;
    logic [HAW-1:0] hist_raddr, hist_waddr;
    logic [MCW-1:0] main_count;
    logic [HCW-1:0] hist_count;
    urs_rsp_t       result;
    logic           rsp_valid_reg;
    urs_rsp_t       rsp_reg;

    // pipeline moves whenever the result register is free or being taken
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && advance;
    assign cmd_ready = advance;

    urs_ptr #(
        .MAIN_DEPTH    (MAIN_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ptr (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (cmd.mode),
        .flags      (flags),
        .main_raddr (main_raddr),
        .main_waddr (main_waddr),
        .hist_raddr (hist_raddr),
        .hist_waddr (hist_waddr),
        .main_count (main_count),
        .hist_count (hist_count)
    );

    urs_exec #(
        .MAIN_DEPTH    (MAIN_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SONG_BITS     (SONG_BITS)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .accept     (accept),
        .song_id    (cmd.song_id),
        .flags      (flags),
        .main_raddr (main_raddr),
        .main_waddr (main_waddr),
        .hist_raddr (hist_raddr),
        .hist_waddr (hist_waddr),
        .main_count (main_count),
        .hist_count (hist_count),
        .busy       (busy),
        .result     (result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= busy;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && busy)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/core/urs_check.sv
// port-level checker for the undo/redo stack pair, bound to the top level
`include "assert_macros.svh"

module urs_check #(
    parameter int HISTORY_DEPTH = 5
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input urs_pkg::urs_cmd_t cmd,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input urs_pkg::urs_rsp_t rsp
);
    import urs_pkg::*;

    // no result beat while in reset
    `URS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !rsp_valid)

    // a stalled result beat holds
    `URS_ASSERT(a_rsp_hold, clk, rst_n,
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

    // commands are refused only behind a result beat that is being held
    `URS_ASSERT(a_cmd_backpressure, clk, rst_n, !cmd_ready |-> rsp_valid && !rsp_ready)

    // a discard only happens on a good undo that leaves the history full
    `URS_ASSERT(a_drop_full, clk, rst_n,
        rsp_valid && rsp.dropped_oldest |->
        rsp.history_count == 3'(HISTORY_DEPTH) && rsp.status == STAT_OK)

    // a redo on an empty history moves nothing
    `URS_ASSERT(a_hist_empty_idle, clk, rst_n,
        rsp_valid && rsp.status == STAT_HIST_EMPTY |->
        rsp.moved_song == 8'd0 && !rsp.dropped_oldest)

endmodule

bind undo_redo_stack_pair urs_check #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
) u_urs_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

>>> verif/urs_checker.sv
// checker for the undo/redo stack pair: stack predictor and result compare
module urs_checker #(
    parameter int MAIN_DEPTH    = 10,
    parameter int HISTORY_DEPTH = 5,
    parameter int SONG_BITS     = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  urs_pkg::urs_cmd_t cmd,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  urs_pkg::urs_rsp_t rsp,
    output int                errors,
    output int                pending
);
    import urs_pkg::*;

    localparam logic [7:0] SONG_MASK =
        (SONG_BITS >= 8) ? 8'hFF : 8'((1 << SONG_BITS) - 1);

    // predicted contents of both stacks
    logic [7:0] main_songs [MAIN_DEPTH];
    logic [7:0] hist_songs [HISTORY_DEPTH];
    int         main_fill;
    int         hist_fill;
    int         hist_head;

    // results still owed by the block, oldest first
    urs_rsp_t   owed_results [$];
    urs_rsp_t   want;

    // apply one command to the predicted stacks and build its result
    function automatic urs_rsp_t apply_stack_op(urs_cmd_t c);
        urs_rsp_t   r;
        logic [7:0] song;
        r    = '0;
        song = c.song_id & SONG_MASK;
        case (c.mode)
            MODE_PUSH:
            begin
                if (main_fill < MAIN_DEPTH)
                begin
                    main_songs[main_fill] = song;
                    main_fill++;
                end
                else
                begin
                    r.status = STAT_MAIN_FULL;
                end
            end
            MODE_UNDO:
            begin
                if (main_fill == 0)
                begin
                    r.status = STAT_MAIN_EMPTY;
                end
                else
                begin
                    main_fill--;
                    r.moved_song = main_songs[main_fill];
                    // full history: oldest entry falls off the ring
                    if (hist_fill >= HISTORY_DEPTH)
                    begin
                        hist_head        = (hist_head + 1) % HISTORY_DEPTH;
                        hist_fill        = HISTORY_DEPTH - 1;
                        r.dropped_oldest = 1'b1;
                    end
                    hist_songs[(hist_head + hist_fill) % HISTORY_DEPTH] = r.moved_song;
                    hist_fill++;
                end
            end
            MODE_REDO:
            begin
                if (hist_fill == 0)
                begin
                    r.status = STAT_HIST_EMPTY;
                end
                else
                begin
                    hist_fill--;
                    r.moved_song = hist_songs[(hist_head + hist_fill) % HISTORY_DEPTH];
                    // main stack full: the popped song is lost
                    if (main_fill < MAIN_DEPTH)
                    begin
                        main_songs[main_fill] = r.moved_song;
                        main_fill++;
                    end
                    else
                    begin
                        r.status = STAT_MAIN_FULL;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.main_count    = main_fill[3:0];
        r.history_count = hist_fill[2:0];
        return r;
    endfunction

    // compare result beats, then predict command beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_fill = 0;
            hist_fill = 0;
            hist_head = 0;
            errors    = 0;
            owed_results.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result beat: status %0d moved %0d dropped %0d",
                                 rsp.status, rsp.moved_song, rsp.dropped_oldest);
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp.status !== want.status || rsp.moved_song !== want.moved_song ||
                        rsp.dropped_oldest !== want.dropped_oldest ||
                        rsp.main_count !== want.main_count ||
                        rsp.history_count !== want.history_count)
                    begin
                        if (errors < 10)
                            $display({"result mismatch: expected status %0d moved %0d ",
                                      "dropped %0d main %0d hist %0d, got status %0d ",
                                      "moved %0d dropped %0d main %0d hist %0d"},
                                     want.status, want.moved_song, want.dropped_oldest,
                                     want.main_count, want.history_count,
                                     rsp.status, rsp.moved_song, rsp.dropped_oldest,
                                     rsp.main_count, rsp.history_count);
                        errors++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                owed_results.push_back(apply_stack_op(cmd));
            pending <= owed_results.size();
        end
    end

endmodule

>>> verif/tb.sv
// testbench top for the undo/redo stack pair: clock, reset, stimulus, verdict
module tb;
    import urs_pkg::*;

    localparam int         MAIN_DEPTH      = 10;
    localparam int         HISTORY_DEPTH   = 5;
    localparam int         SONG_BITS       = 8;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         ITEMS_PER_PHASE = 610;
    // all-zero, all-one and alternating songs for the directed pushes
    localparam logic [31:0] EDGE_SONGS     = 32'h00FF_AA55;

    logic     clk;
    logic     rst_n;
    logic     cmd_valid   = 1'b0;
    logic     cmd_ready;
    urs_cmd_t cmd         = '0;
    logic     rsp_valid;
    logic     rsp_ready   = 1'b0;
    urs_rsp_t rsp;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    int       check_errors;
    int       check_pending;

    undo_redo_stack_pair #(
        .MAIN_DEPTH    (MAIN_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SONG_BITS     (SONG_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    urs_checker #(
        .MAIN_DEPTH    (MAIN_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SONG_BITS     (SONG_BITS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (check_errors),
        .pending   (check_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // send one command beat, with random idle cycles ahead of it
    task automatic send_cmd(input logic [1:0] mode, input logic [7:0] song);
        urs_cmd_t c;
        c.mode    = mode;
        c.song_id = song;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // hold off the sender until every owed result has come back
    task automatic wait_results;
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (check_pending != 0);
        @(posedge clk);
    endtask

    // push-, undo-, redo-heavy and mixed runs to reach full and empty stacks
    task automatic random_traffic(input int n_items);
        int         sent;
        int         run_left;
        int         bias;
        int         pick;
        logic [1:0] mode;
        sent     = 0;
        run_left = 0;
        bias     = 0;
        while (sent < n_items)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(40, 8);
                bias     = $urandom_range(3);
            end
            pick = $urandom_range(99);
            if (pick < 2)
                mode = MODE_UNUSED;
            else
                case (bias)
                    0:       mode = (pick < 75) ? MODE_PUSH : (pick < 90) ? MODE_UNDO : MODE_REDO;
                    1:       mode = (pick < 20) ? MODE_PUSH : (pick < 80) ? MODE_UNDO : MODE_REDO;
                    2:       mode = (pick < 25) ? MODE_PUSH : (pick < 45) ? MODE_UNDO : MODE_REDO;
                    default: mode = (pick < 40) ? MODE_PUSH : (pick < 70) ? MODE_UNDO : MODE_REDO;
                endcase
            send_cmd(mode, 8'($urandom_range(255)));
            if (mode != MODE_UNUSED)
                sent++;
            run_left--;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        // reset edge lands after every block is waiting on it
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        tx_idle_pct = 31;
        rx_idle_pct <= 87;

        // empty-stack cases and the unused mode
        send_cmd(MODE_REDO, 8'hFF);
        send_cmd(MODE_UNDO, 8'h00);
        send_cmd(MODE_UNUSED, 8'h5A);
        // fill the main stack, then push onto a full one
        for (int i = 0; i < MAIN_DEPTH; i++)
            send_cmd(MODE_PUSH, (i < 4) ? EDGE_SONGS[8 * i +: 8] : 8'($urandom_range(255)));
        send_cmd(MODE_PUSH, 8'h11);
        // overfill the history so the oldest entry drops
        repeat (HISTORY_DEPTH + 1)
            send_cmd(MODE_UNDO, 8'($urandom_range(255)));
        // refill main, then redo into a full main stack
        repeat (HISTORY_DEPTH + 1)
            send_cmd(MODE_PUSH, 8'($urandom_range(255)));
        send_cmd(MODE_REDO, 8'h00);
        wait_results();

        random_traffic(ITEMS_PER_PHASE);
        wait_results();

        // sender idles heavily, receiver lightly
        tx_idle_pct = 87;
        rx_idle_pct <= 31;
        random_traffic(ITEMS_PER_PHASE);
        wait_results();

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        random_traffic(ITEMS_PER_PHASE);
        wait_results();

        repeat (8) @(negedge clk);
        if (check_errors == 0 && check_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/urs_pkg.sv
rtl/core/urs_ram.sv
rtl/core/urs_ptr.sv
rtl/core/urs_exec.sv
rtl/core/undo_redo_stack_pair.sv
rtl/core/urs_check.sv
verif/urs_checker.sv
verif/tb.sv
